@@ rtl/core/kth_ancestor_binary_lifting_defines.svh @@
// Assertion macros for the k-th ancestor engine checker.
// Needs nothing else; include by bare file name.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KABL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kabl port check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define KABL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kabl port check failed (next cycle)");

`endif

@@ rtl/core/kabl_pkg.sv @@
// Shared types, constants and helpers for the k-th ancestor engine.
// Used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package kabl_pkg;

    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 20;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int NODE_W = 10;
    localparam int DIST_W = 20;
    localparam int CNT_W  = 11;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int ENTRY_W = NODE_W + 1;
    localparam int DEPTH   = MAX_NODES * LEVELS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EFF_W   = (CNT_W > $clog2(MAX_NODES + 1)) ? CNT_W : $clog2(MAX_NODES + 1);

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(1024);

    // Distance bits that map onto existing table levels
    localparam logic [DIST_W-1:0] DIST_MASK = (LEVELS >= DIST_W) ? {DIST_W{1'b1}} :
                                               DIST_W'((64'd1 << LEVELS) - 64'd1);

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Register index (paddr word bits)
    localparam logic [PADDR_W-3:0] REG_NODE_COUNT = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_RDA,
        ST_B_CHKA,
        ST_B_CHKB,
        ST_Q_STEP,
        ST_Q_CHK
    } state_t;

    typedef struct packed {
        logic load_write;
        logic b_init;
        logic b_rd_a;
        logic b_rd_b;
        logic b_write;
        logic b_step;
        logic q_init;
        logic q_rd;
        logic q_shift;
        logic q_take;
        logic res_found;
        logic res_fail;
    } cmd_t;

    typedef struct packed {
        logic query_ok;
        logic build_empty;
        logic dist_zero;
        logic dist_lsb;
        logic entry_ok;
        logic v_last;
        logic lvl_last;
    } status_t;

    // Table entry (v, j) lives at j*MAX_NODES + v
    function automatic logic [ADDR_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [IDX_W-1:0] idx);
        return ADDR_W'(lvl) * ADDR_W'(MAX_NODES) + ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/core/kabl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module kabl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/kabl_ctrl.sv @@
// Controller state machine for the k-th ancestor engine.
// Depends on kabl_pkg; drives the datapath by command and reads its status.
`timescale 1ns / 1ps

module kabl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kabl_pkg::FUNC_W-1:0] func,
    input  kabl_pkg::status_t           status,
    output kabl_pkg::cmd_t              cmd,
    output logic                        busy
);

    import kabl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_BUILD && !status.build_empty)
                    begin
                        state_next = ST_B_RDA;
                    end
                    else if (func == FUNC_QUERY && status.query_ok)
                    begin
                        state_next = ST_Q_STEP;
                    end
                end
            end
            ST_B_RDA:
            begin
                state_next = ST_B_CHKA;
            end
            ST_B_CHKA,
            ST_B_CHKB:
            begin
                if (state_reg == ST_B_CHKA && status.entry_ok)
                begin
                    state_next = ST_B_CHKB;
                end
                else if (status.v_last && status.lvl_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_B_RDA;
                end
            end
            ST_Q_STEP:
            begin
                if (status.dist_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.dist_lsb)
                begin
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK:
            begin
                state_next = status.entry_ok ? ST_Q_STEP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            cmd.load_write = 1'b1;
                        end
                        FUNC_BUILD:
                        begin
                            cmd.b_init = !status.build_empty;
                        end
                        FUNC_QUERY:
                        begin
                            cmd.q_init   = status.query_ok;
                            cmd.res_fail = !status.query_ok;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_B_RDA:
            begin
                cmd.b_rd_a = 1'b1;
            end
            ST_B_CHKA:
            begin
                // Present parent: fetch its entry; else store absent now
                if (status.entry_ok)
                begin
                    cmd.b_rd_b = 1'b1;
                end
                else
                begin
                    cmd.b_write = 1'b1;
                    cmd.b_step  = 1'b1;
                end
            end
            ST_B_CHKB:
            begin
                cmd.b_write = 1'b1;
                cmd.b_step  = 1'b1;
            end
            ST_Q_STEP:
            begin
                if (status.dist_zero)
                begin
                    cmd.res_found = 1'b1;
                end
                else if (status.dist_lsb)
                begin
                    cmd.q_rd = 1'b1;
                end
                else
                begin
                    cmd.q_shift = 1'b1;
                end
            end
            ST_Q_CHK:
            begin
                cmd.q_take   = status.entry_ok;
                cmd.res_fail = !status.entry_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/kabl_datapath.sv @@
// Datapath for the k-th ancestor engine: jump table RAM, walk registers, result register.
// Depends on kabl_pkg and kabl_ram.
`timescale 1ns / 1ps

module kabl_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kabl_pkg::cmd_t              cmd,
    output kabl_pkg::status_t           status,
    input  logic [kabl_pkg::CNT_W-1:0]  node_count,
    input  logic [kabl_pkg::NODE_W-1:0] node,
    input  logic                        parent_present,
    input  logic [kabl_pkg::NODE_W-1:0] parent,
    input  logic [kabl_pkg::DIST_W-1:0] distance,
    output logic                        result_valid,
    output logic [kabl_pkg::NODE_W-1:0] ancestor,
    output logic                        found
);

    import kabl_pkg::*;

    logic [EFF_W-1:0]   eff_count;
    logic [ENTRY_W-1:0] rdata;
    logic [NODE_W-1:0]  target;
    logic               entry_ok;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;
    logic [LVL_W-1:0]   lvl_prev;

    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] cur_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [LVL_W-1:0]  lvl_reg;
    logic [LVL_W-1:0]  lvl_next;
    logic [IDX_W-1:0]  v_reg;
    logic [IDX_W-1:0]  v_next;

    logic              result_valid_reg;
    logic [NODE_W-1:0] ancestor_reg;
    logic              found_reg;

    assign eff_count = (EFF_W'(node_count) < EFF_W'(MAX_NODES)) ? EFF_W'(node_count)
                                                                 : EFF_W'(MAX_NODES);

    assign target   = rdata[NODE_W-1:0];
    assign entry_ok = rdata[ENTRY_W-1] && (EFF_W'(target) < eff_count);
    assign lvl_prev = lvl_reg - LVL_W'(1);

    kabl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (cmd.b_rd_b)
        begin
            raddr = node_addr(lvl_prev, IDX_W'(target));
        end
        else if (cmd.b_rd_a)
        begin
            raddr = node_addr(lvl_prev, v_reg);
        end
        else
        begin
            raddr = node_addr(lvl_reg, IDX_W'(cur_reg));
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = node_addr(lvl_reg, v_reg);
        wdata = {entry_ok, entry_ok ? target : {NODE_W{1'b0}}};
        if (cmd.load_write)
        begin
            // Load ignores nodes beyond the table
            we    = (32'(node) < MAX_NODES);
            waddr = node_addr(LVL_W'(0), IDX_W'(node));
            wdata = {parent_present, parent_present ? parent : {NODE_W{1'b0}}};
        end
        else if (cmd.b_write)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        dist_next = dist_reg;
        lvl_next  = lvl_reg;
        v_next    = v_reg;
        if (cmd.q_init)
        begin
            cur_next  = node;
            dist_next = distance;
            lvl_next  = LVL_W'(0);
        end
        if (cmd.q_shift || cmd.q_take)
        begin
            dist_next = dist_reg >> 1;
            lvl_next  = lvl_reg + LVL_W'(1);
        end
        if (cmd.q_take)
        begin
            cur_next = target;
        end
        if (cmd.b_init)
        begin
            v_next   = '0;
            lvl_next = LVL_W'(1);
        end
        if (cmd.b_step)
        begin
            // Advance to the next node, or wrap to the next level
            if (status.v_last)
            begin
                v_next   = '0;
                lvl_next = lvl_reg + LVL_W'(1);
            end
            else
            begin
                v_next = v_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dist_reg <= dist_next;
        lvl_reg  <= lvl_next;
        v_reg    <= v_next;
        if (cmd.res_found || cmd.res_fail)
        begin
            ancestor_reg <= cmd.res_found ? cur_reg : {NODE_W{1'b0}};
            found_reg    <= cmd.res_found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.res_found || cmd.res_fail;
        end
    end

    assign status.query_ok    = (EFF_W'(node) < eff_count) && ((distance & ~DIST_MASK) == '0);
    assign status.build_empty = (eff_count == '0) || (LEVELS == 1);
    assign status.dist_zero   = (dist_reg == '0);
    assign status.dist_lsb    = dist_reg[0];
    assign status.entry_ok    = entry_ok;
    assign status.v_last      = ((EFF_W'(v_reg) + EFF_W'(1)) == eff_count);
    assign status.lvl_last    = (lvl_reg == LVL_W'(LEVELS - 1));

    assign result_valid = result_valid_reg;
    assign ancestor     = ancestor_reg;
    assign found        = found_reg;

endmodule

@@ rtl/core/kth_ancestor_binary_lifting.sv @@
// Top level of the binary-lifting k-th ancestor engine.
// Depends on kabl_pkg, kabl_ctrl, kabl_datapath (which holds kabl_ram).
//
// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              func, node, parent_present, parent, distance
// result    out        result_valid (1 cycle)     ancestor, found
// config    in/out     psel & penable & pwrite    node_count at byte address 0
//
// Load writes the level-0 entry and leaves busy low. A query walks the distance bits from
// the lowest up to the highest set bit: a clear bit only shifts, a set bit reads the jump
// table RAM through its one read port and checks the entry. Build fills levels 1 to
// LEVELS - 1 for the first min(node_count, MAX_NODES) nodes, reading a present parent's
// entry too. The table is not cleared after reset; node_count resets to 1024.
// busy is high while a build or query walks; the result strobe cannot be stalled.
`timescale 1ns / 1ps

module kth_ancestor_binary_lifting (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [kabl_pkg::FUNC_W-1:0]  func,
    input  logic [kabl_pkg::NODE_W-1:0]  node,
    input  logic                         parent_present,
    input  logic [kabl_pkg::NODE_W-1:0]  parent,
    input  logic [kabl_pkg::DIST_W-1:0]  distance,
    output logic                         result_valid,
    output logic [kabl_pkg::NODE_W-1:0]  ancestor,
    output logic                         found,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kabl_pkg::PADDR_W-1:0] paddr,
    input  logic [kabl_pkg::PDATA_W-1:0] pwdata,
    output logic [kabl_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import kabl_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [CNT_W-1:0] node_count_reg;
    logic [CNT_W-1:0] node_count_next;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_NODE_COUNT);

    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            node_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = reg_hit ? PDATA_W'(node_count_reg) : {PDATA_W{1'b0}};

    kabl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    kabl_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .node_count     (node_count_reg),
        .node           (node),
        .parent_present (parent_present),
        .parent         (parent),
        .distance       (distance),
        .result_valid   (result_valid),
        .ancestor       (ancestor),
        .found          (found)
    );

endmodule

@@ rtl/core/kabl_checker.sv @@
// Port-level checker for the k-th ancestor engine, bound to the top level.
// Depends on kabl_pkg and kth_ancestor_binary_lifting_defines.svh.
`timescale 1ns / 1ps
`include "kth_ancestor_binary_lifting_defines.svh"

module kabl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [kabl_pkg::FUNC_W-1:0] func,
    input logic                        result_valid,
    input logic [kabl_pkg::NODE_W-1:0] ancestor,
    input logic                        found
);

    import kabl_pkg::*;

    logic accept;

    assign accept = start && !busy;

    // Only a query transaction may produce a result
    `KABL_ASSERT_NEXT(a_no_result_unless_query, clk, rst_n, accept && (func != FUNC_QUERY), !result_valid)

    // A load completes in its own cycle
    `KABL_ASSERT_NEXT(a_load_single_cycle, clk, rst_n, accept && (func == FUNC_LOAD), !busy)

    // The engine is back to idle when a result is shown
    `KABL_ASSERT_NOW(a_idle_at_result, clk, rst_n, result_valid, !busy)

    // A missing ancestor reads as zero
    `KABL_ASSERT_NOW(a_absent_is_zero, clk, rst_n, result_valid && !found, ancestor == '0)

endmodule

bind kth_ancestor_binary_lifting kabl_checker u_kabl_checker (.*);

@@ dv/kabl_lift_checker.sv @@
// Checker for the k-th ancestor engine: watches command, result and APB write traffic,
// keeps its own jump table and node count, and compares every result in order.
// Depends on kabl_pkg.
`timescale 1ns / 1ps

module kabl_lift_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [kabl_pkg::FUNC_W-1:0]  func,
    input  logic [kabl_pkg::NODE_W-1:0]  node,
    input  logic                         parent_present,
    input  logic [kabl_pkg::NODE_W-1:0]  parent,
    input  logic [kabl_pkg::DIST_W-1:0]  distance,
    input  logic                         result_valid,
    input  logic [kabl_pkg::NODE_W-1:0]  ancestor,
    input  logic                         found,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [kabl_pkg::PADDR_W-1:0] paddr,
    input  logic [kabl_pkg::PDATA_W-1:0] pwdata,
    output int                           errors,
    output int                           pending
);
    import kabl_pkg::*;

    localparam int HOP_ENTRIES = MAX_NODES * LEVELS;

    typedef struct packed {
        logic              present;
        logic [NODE_W-1:0] target;
    } hop_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              found;
    } answer_t;

    // entry (v, lvl) sits at lvl * MAX_NODES + v
    hop_t             hop [HOP_ENTRIES];
    logic [CNT_W-1:0] node_limit;
    answer_t          awaited_answers [$];

    function automatic int eff_nodes();
        return (node_limit < MAX_NODES) ? int'(node_limit) : MAX_NODES;
    endfunction

    // a target at or beyond the node count counts as absent
    function automatic bit hop_target(input int v, input int lvl, output int dst);
        hop_t e;
        e = hop[lvl * MAX_NODES + v];
        dst = int'(e.target);
        return e.present && (int'(e.target) < eff_nodes());
    endfunction

    function automatic void rebuild_levels();
        int   lim;
        int   lvl;
        int   v;
        int   mid;
        int   far;
        hop_t e;
        lim = eff_nodes();
        for (lvl = 1; lvl < LEVELS; lvl++)
        begin
            for (v = 0; v < lim; v++)
            begin
                e = '0;
                if (hop_target(v, lvl - 1, mid) && hop_target(mid, lvl - 1, far))
                begin
                    e.present = 1'b1;
                    e.target  = NODE_W'(far);
                end
                hop[lvl * MAX_NODES + v] = e;
            end
        end
    endfunction

    function automatic answer_t walk_up(input logic [NODE_W-1:0] from,
                                        input logic [DIST_W-1:0] steps);
        answer_t a;
        int      cur;
        int      nxt;
        int      lvl;
        bit      ok;
        ok  = int'(from) < eff_nodes();
        cur = int'(from);
        for (lvl = 0; lvl < DIST_W; lvl++)
        begin
            if (ok && steps[lvl])
            begin
                if (lvl >= LEVELS || !hop_target(cur, lvl, nxt))
                    ok = 1'b0;
                else
                    cur = nxt;
            end
        end
        a.found    = ok;
        a.ancestor = ok ? NODE_W'(cur) : '0;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < HOP_ENTRIES; i++)
                hop[i] = '0;
            node_limit = NODE_COUNT_RESET;
            awaited_answers.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            // results belong to earlier queries, so retire before taking a new one
            if (result_valid)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual ancestor %0d found %0d",
                             $time, ancestor, found);
                    errors = errors + 1;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t found mismatch: expected %0d, actual %0d",
                                 $time, want.found, found);
                        errors = errors + 1;
                    end
                    if (ancestor !== want.ancestor)
                    begin
                        $display("%0t ancestor mismatch: expected %0d, actual %0d",
                                 $time, want.ancestor, ancestor);
                        errors = errors + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready
                    && paddr[PADDR_W-1:2] == REG_NODE_COUNT)
                node_limit = pwdata[CNT_W-1:0];
            if (start && !busy)
            begin
                case (func)
                    FUNC_LOAD:
                        hop[int'(node)] = parent_present ? {1'b1, parent} : '0;
                    FUNC_BUILD:
                        rebuild_levels();
                    FUNC_QUERY:
                        awaited_answers = {awaited_answers, walk_up(node, distance)};
                    default: ;
                endcase
            end
            pending <= awaited_answers.size();
        end
    end

endmodule

@@ dv/kth_ancestor_binary_lifting_test.sv @@
// Top of the k-th ancestor engine testbench: clock, reset, command and APB stimulus,
// watchdog and verdict. Depends on kabl_pkg, kabl_lift_checker and the engine RTL.
`timescale 1ns / 1ps

module kth_ancestor_binary_lifting_test;
    import kabl_pkg::*;

    localparam int STALL_LIMIT = 4 * 3 * MAX_NODES * LEVELS;
    localparam int TAIL_CYCLES = 64;
    localparam int NODE_TOP    = MAX_NODES - 1;

    localparam logic [PADDR_W-3:0] REG_SPARE  = 1'b1;
    localparam logic [FUNC_W-1:0]  FUNC_SPARE = 2'd3;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func           = FUNC_LOAD;
    logic [NODE_W-1:0]   node           = '0;
    logic                parent_present = 1'b0;
    logic [NODE_W-1:0]   parent         = '0;
    logic [DIST_W-1:0]   distance       = '0;
    logic                result_valid;
    logic [NODE_W-1:0]   ancestor;
    logic                found;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [PDATA_W-1:0]  pwdata         = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int sent_count   = 0;
    bit calm         = 1'b0;

    always #5 clk = ~clk;

    kth_ancestor_binary_lifting dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .node(node), .parent_present(parent_present),
        .parent(parent), .distance(distance),
        .result_valid(result_valid), .ancestor(ancestor), .found(found),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    kabl_lift_checker lift_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .node(node), .parent_present(parent_present),
        .parent(parent), .distance(distance),
        .result_valid(result_valid), .ancestor(ancestor), .found(found),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_node(input int lim);
        if (lim == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, NODE_TOP);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return DIST_W'($urandom_range(0, lim + 1));
        if (r < 65)
            return DIST_W'($urandom_range(0, 15));
        if (r < 85)
            return DIST_W'($urandom);
        return DIST_W'(1) << $urandom_range(0, DIST_W - 1);
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input int n, input logic pp,
                            input int par, input logic [DIST_W-1:0] d);
        int gap;
        if (sent_count % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        func           <= f;
        node           <= NODE_W'(n);
        parent_present <= pp;
        parent         <= NODE_W'(par);
        distance       <= d;
        // hold the transaction until the engine takes it
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic do_load(input int n, input logic pp, input int par);
        send_cmd(FUNC_LOAD, n, pp, par, DIST_W'($urandom));
    endtask

    task automatic do_query(input int n, input logic [DIST_W-1:0] d);
        send_cmd(FUNC_QUERY, n, 1'($urandom), $urandom_range(0, NODE_TOP), d);
    endtask

    task automatic do_build();
        send_cmd(FUNC_BUILD, $urandom_range(0, NODE_TOP), 1'($urandom),
                 $urandom_range(0, NODE_TOP), DIST_W'($urandom));
    endtask

    task automatic do_spare();
        send_cmd(FUNC_SPARE, $urandom_range(0, NODE_TOP), 1'($urandom),
                 $urandom_range(0, NODE_TOP), DIST_W'($urandom));
    endtask

    // mostly short hops toward node 0 for deep chains; some roots, cycles and far parents
    task automatic load_random_parent(input int v, input int lim);
        int r;
        int par;
        r   = $urandom_range(0, 99);
        par = $urandom_range(0, NODE_TOP);
        if (r < 8)
            do_load(v, 1'b0, par);
        else begin
            if (r < 78 && v > 0)
                par = v - int'($urandom_range(1, (v < 3) ? v : 3));
            else if (r < 90 && lim > 0)
                par = $urandom_range(0, lim - 1);
            else if (r >= 96)
                par = v;
            do_load(v, 1'b1, par);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        // a load or build may still be in flight without a result to wait for
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [PADDR_W-3:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_checks();
        cfg_write(REG_NODE_COUNT, 4);
        cfg_write(REG_SPARE, 0);
        // chain 3 -> 2 -> 1 -> 0
        do_load(0, 1'b0, NODE_TOP);
        do_load(1, 1'b1, 0);
        do_load(2, 1'b1, 1);
        do_load(3, 1'b1, 2);
        do_load(NODE_TOP, 1'b1, NODE_TOP);
        do_build();
        do_query(3, 0);
        do_query(3, 1);
        do_query(3, 2);
        do_query(3, 3);
        do_query(3, 4);
        do_query(0, 0);
        do_query(NODE_TOP, 0);
        do_query(3, '1);
        do_query(3, DIST_W'(1) << (DIST_W - 1));
        do_query(2, DIST_W'(2));
        do_spare();
        // parent beyond the node count reads as absent
        do_load(2, 1'b1, 1000);
        do_query(2, 1);
        do_query(3, 2);
        do_build();
        do_query(3, 2);
        do_query(3, 1);
    endtask

    task automatic run_phase(input int cnt, input bit fresh, input int n_mix);
        int lim;
        int v;
        int k;
        int r;
        settle();
        cfg_write(REG_NODE_COUNT, cnt);
        lim = (cnt < MAX_NODES) ? cnt : MAX_NODES;
        if (fresh) begin
            for (v = 0; v < lim; v++)
                load_random_parent(v, lim);
            do_build();
        end
        for (k = 0; k < n_mix; k++) begin
            r = $urandom_range(0, 99);
            if (r < 62)
                do_query(pick_node(lim), pick_distance(lim));
            else if (r < 85)
                load_random_parent(pick_node(lim), lim);
            else if (r < 90 && lim <= 128)
                do_build();
            else if (r < 95)
                do_spare();
            else
                do_query($urandom_range(0, NODE_TOP), DIST_W'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        run_phase(1, 1'b1, 40);
        run_phase(0, 1'b0, 20);
        run_phase(2, 1'b1, 60);
        run_phase(7, 1'b1, 80);
        run_phase(33, 1'b1, 110);
        run_phase(100, 1'b1, 100);
        run_phase(MAX_NODES, 1'b1, 120);
        run_phase(2047, 1'b0, 50);
        run_phase(MAX_NODES - 1, 1'b0, 50);
        run_phase(16, 1'b1, 90);
        run_phase(64, 1'b1, 90);
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/kabl_pkg.sv
rtl/core/kabl_ram.sv
rtl/core/kabl_ctrl.sv
rtl/core/kabl_datapath.sv
rtl/core/kth_ancestor_binary_lifting.sv
rtl/core/kabl_checker.sv
dv/kabl_lift_checker.sv
dv/kth_ancestor_binary_lifting_test.sv
